[rtl/mesh3d_neighbor_list_assert.svh]
// Assertion macros for the 3-D mesh neighbour list block.
`ifndef MESH3D_NEIGHBOR_LIST_ASSERT_SVH
`define MESH3D_NEIGHBOR_LIST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define M3NL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define M3NL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/m3nl_pkg.sv]
// Package: types, constants and divider step for the 3-D mesh neighbour list.
`default_nettype none

package m3nl_pkg;

  localparam int unsigned ID_W      = 12;   // node number width
  localparam int unsigned CNT_W     = 13;   // node count register width
  localparam int unsigned EDGE_W    = 5;    // edge register width
  localparam int unsigned SQ_W      = 10;   // edge squared
  localparam int unsigned NUM_DIRS  = 6;
  localparam int unsigned DIV_BITS  = 4;    // quotient bits resolved per stage
  localparam int unsigned DIV_STAGES = 6;   // two 12-bit divisions
  localparam int unsigned NUM_STAGES = 8;   // divider stages, candidates, packing

  localparam logic [2:0] MAX_COUNT = 3'd6;

  // Configuration register indexes
  localparam logic [0:0] REG_NODE_COUNT = 1'b0;
  localparam logic [0:0] REG_EDGE_WIDTH = 1'b1;

  // Divider stage word: quo shifts the dividend out and the quotient in
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic              bad;
    logic [EDGE_W-1:0] z;
    logic [ID_W-1:0]   quo;
    logic [EDGE_W-1:0] rem;
  } div_t;

  typedef struct packed {
    logic                          bad;
    logic [NUM_DIRS-1:0]           keep;
    logic [NUM_DIRS-1:0][ID_W-1:0] idx;
  } cand_t;

  typedef struct packed {
    logic                          bad;
    logic [2:0]                    count;
    logic [NUM_DIRS-1:0][ID_W-1:0] nb;
  } out_t;

  // DIV_BITS restoring division steps by w (w >= 1)
  function automatic div_t div_steps(div_t d, logic [EDGE_W-1:0] w);
    logic [EDGE_W:0] part;
    div_t            res;
    res = d;
    for (int k = 0; k < DIV_BITS; k++) begin
      part    = {res.rem, res.quo[ID_W-1]};
      res.quo = {res.quo[ID_W-2:0], 1'b0};
      if (part >= {1'b0, w}) begin
        part       = part - {1'b0, w};
        res.quo[0] = 1'b1;
      end
      res.rem = part[EDGE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/mesh3d_neighbor_list.sv]
// Top level: 3-D mesh face-neighbour lookup, pipelined, one query per cycle unless m_axis stalls.
//
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+---------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready    | tdata[11:0] node_id
//  m_axis    | out | m_axis_tvalid / m_axis_tready    | tdata[74:0] count, neighbour 0..5;
//            |     |                                  | tuser[0] bad_node
//  cfg       | in  | cfg_valid / cfg_ready            | cfg_index, cfg_data
//
//  One word accepted per cycle while a stall on m_axis does not hold the pipeline.
//  Six divider stages (4 quotient bits each: id / w, then (id / w) / w) set the depth,
//  then one stage for the candidates and one for packing into the output register.
//  Each stage has its own valid bit and moves when the stage after it is free, so
//  bubbles close up and a stall on m_axis backs up without loss or repetition.
//  Synchronous reset clears the valid bits and sets node_count and edge to 1.
//  cfg_ready is always high; writes are expected only while the pipeline is empty.
`default_nettype none

module mesh3d_neighbor_list #(
  parameter int unsigned MAX_NODES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // config write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  // query in
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [11:0] node_id
  // result out
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // [2:0] neighbor_count, [14:3] neighbor_0,
                                           // [26:15] neighbor_1, [38:27] neighbor_2,
                                           // [50:39] neighbor_3, [62:51] neighbor_4,
                                           // [74:63] neighbor_5
  output logic [0:0]       m_axis_tuser    // [0] bad_node
);

  localparam int unsigned ID_W   = m3nl_pkg::ID_W;
  localparam int unsigned CNT_W  = m3nl_pkg::CNT_W;
  localparam int unsigned EDGE_W = m3nl_pkg::EDGE_W;
  localparam int unsigned SQ_W   = m3nl_pkg::SQ_W;
  localparam int unsigned NDIR   = m3nl_pkg::NUM_DIRS;
  localparam int unsigned NST    = m3nl_pkg::NUM_STAGES;
  localparam int unsigned NDIV   = m3nl_pkg::DIV_STAGES;
  // node count is capped at MAX_NODES; the register cannot exceed 2^13-1 anyway
  localparam int unsigned CNT_MAX = (1 << CNT_W) - 1;
  localparam int unsigned LIM_CAP = (MAX_NODES > CNT_MAX) ? CNT_MAX : MAX_NODES;
  localparam int unsigned CAND_W  = ID_W + 1;

  // ---------------------------------------------------------------------------
  // Configuration: stored already cleaned up (limit capped, zero edge read as 1)
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]  limit;
  logic [EDGE_W-1:0] edge_w;
  logic [SQ_W-1:0]   edge_sq;
  logic [EDGE_W-1:0] edge_wr;
  logic [2*EDGE_W-1:0] sq_wr;

  assign cfg_ready = 1'b1;
  assign edge_wr   = (cfg_data[EDGE_W-1:0] == '0) ? EDGE_W'(1) : cfg_data[EDGE_W-1:0];
  assign sq_wr     = edge_wr * edge_wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit   <= CNT_W'(1);
      edge_w  <= EDGE_W'(1);
      edge_sq <= SQ_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        m3nl_pkg::REG_NODE_COUNT: begin
          limit <= (cfg_data > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : cfg_data;
        end
        m3nl_pkg::REG_EDGE_WIDTH: begin
          edge_w  <= edge_wr;
          edge_sq <= sq_wr[SQ_W-1:0];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: stage i moves when empty or when stage i+1 moves
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic [NST-1:0] vld_in;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || m_axis_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign vld_in        = {vld[NST-2:0], s_axis_tvalid};
  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) vld[i] <= vld_in[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 0..5: id / w (gives z), then (id / w) / w (gives x and y)
  // ---------------------------------------------------------------------------
  m3nl_pkg::div_t dv      [NDIV];
  m3nl_pkg::div_t dv_next [NDIV];
  m3nl_pkg::div_t seed_a;
  m3nl_pkg::div_t seed_b;
  logic [ID_W-1:0] in_id;

  assign in_id = s_axis_tdata[ID_W-1:0];

  always_comb begin
    seed_a.id  = in_id;
    seed_a.bad = ({1'b0, in_id} >= limit);
    seed_a.z   = '0;
    seed_a.quo = in_id;
    seed_a.rem = '0;

    // second division starts from the first quotient; its remainder is z
    seed_b     = dv[2];
    seed_b.z   = dv[2].rem;
    seed_b.rem = '0;

    dv_next[0] = m3nl_pkg::div_steps(seed_a, edge_w);
    dv_next[1] = m3nl_pkg::div_steps(dv[0], edge_w);
    dv_next[2] = m3nl_pkg::div_steps(dv[1], edge_w);
    dv_next[3] = m3nl_pkg::div_steps(seed_b, edge_w);
    dv_next[4] = m3nl_pkg::div_steps(dv[3], edge_w);
    dv_next[5] = m3nl_pkg::div_steps(dv[4], edge_w);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NDIV; i++) begin
      if (en[i]) dv[i] <= dv_next[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: candidates in order x-1, y-1, z-1, x+1, y+1, z+1.
  // Only the changed coordinate and the linear index are tested; x may sit at
  // or above the edge when node_count exceeds edge cubed.
  // ---------------------------------------------------------------------------
  m3nl_pkg::cand_t cd;
  m3nl_pkg::cand_t cd_next;
  logic [ID_W-1:0]   cx;
  logic [EDGE_W-1:0] cy;
  logic [EDGE_W-1:0] cz;
  logic [ID_W-1:0]   cid;
  logic [CAND_W-1:0] up_x, up_y, up_z;
  logic [CAND_W-1:0] dn_x, dn_y, dn_z;
  logic [NDIR-1:0]   keep;

  assign cx  = dv[NDIV-1].quo;
  assign cy  = dv[NDIV-1].rem;
  assign cz  = dv[NDIV-1].z;
  assign cid = dv[NDIV-1].id;

  always_comb begin
    dn_x = {1'b0, cid} - CAND_W'(edge_sq);
    dn_y = {1'b0, cid} - CAND_W'(edge_w);
    dn_z = {1'b0, cid} - CAND_W'(1);
    up_x = {1'b0, cid} + CAND_W'(edge_sq);
    up_y = {1'b0, cid} + CAND_W'(edge_w);
    up_z = {1'b0, cid} + CAND_W'(1);

    keep[0] = (cx != '0) && (cx <= ID_W'(edge_w));
    keep[1] = (cy != '0);
    keep[2] = (cz != '0);
    keep[3] = (({1'b0, cx} + CAND_W'(1)) < CAND_W'(edge_w)) && (up_x < CAND_W'(limit));
    keep[4] = (({1'b0, cy} + (EDGE_W+1)'(1)) < {1'b0, edge_w}) && (up_y < CAND_W'(limit));
    keep[5] = (({1'b0, cz} + (EDGE_W+1)'(1)) < {1'b0, edge_w}) && (up_z < CAND_W'(limit));

    cd_next.bad    = dv[NDIV-1].bad;
    cd_next.keep   = dv[NDIV-1].bad ? '0 : keep;
    cd_next.idx[0] = dn_x[ID_W-1:0];
    cd_next.idx[1] = dn_y[ID_W-1:0];
    cd_next.idx[2] = dn_z[ID_W-1:0];
    cd_next.idx[3] = up_x[ID_W-1:0];
    cd_next.idx[4] = up_y[ID_W-1:0];
    cd_next.idx[5] = up_z[ID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[NDIV]) cd <= cd_next;
  end

  // ---------------------------------------------------------------------------
  // Stage 7: pack kept candidates from slot 0; this is the output register
  // ---------------------------------------------------------------------------
  m3nl_pkg::out_t ob;
  m3nl_pkg::out_t ob_next;
  logic [2:0]     slot;

  always_comb begin
    slot        = '0;
    ob_next.bad = cd.bad;
    ob_next.nb  = '0;
    for (int d = 0; d < NDIR; d++) begin
      if (cd.keep[d]) begin
        ob_next.nb[slot] = cd.idx[d];
        slot             = slot + 3'd1;
      end
    end
    ob_next.count = slot;
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) ob <= ob_next;
  end

  assign m_axis_tvalid = vld[NST-1];
  assign m_axis_tdata  = {5'b0, ob.nb, ob.count};
  assign m_axis_tuser  = ob.bad;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `include "mesh3d_neighbor_list_assert.svh"

  `M3NL_ASSERT_IMP(a_bad_no_cand, vld[NDIV] && cd.bad, cd.keep == '0, "bad node kept a candidate")
  `M3NL_ASSERT_IMP(a_bad_empty, vld[NST-1] && ob.bad, ob.count == 3'd0, "bad node with neighbours")
  `M3NL_ASSERT_IMP(a_count_max, vld[NST-1], ob.count <= m3nl_pkg::MAX_COUNT, "count above six")
  `M3NL_ASSERT_NXT(a_cand_hold, vld[NDIV] && !en[NDIV], vld[NDIV] && $stable(cd), "stalled word lost")

endmodule

`default_nettype wire

[sim/mesh3d_neighbor_list_tb.sv]
// Self-checking testbench for the 3-D mesh face-neighbour lookup.
`timescale 1ns / 100ps

module mesh3d_neighbor_list_tb;

  localparam int unsigned ID_W     = m3nl_pkg::ID_W;
  localparam int unsigned CNT_W    = m3nl_pkg::CNT_W;
  localparam int unsigned EDGE_W   = m3nl_pkg::EDGE_W;
  localparam int unsigned NUM_DIRS = m3nl_pkg::NUM_DIRS;

  localparam int NODE_LIMIT = 4096;    // MAX_NODES of the instance
  localparam int LATENCY    = 8;       // input word to output word through the top level pipeline
  localparam int NUM_PHASES = 13;      // settings after the directed part: four fixed, the rest random
  localparam int PHASE_LEN  = 72;      // queries per setting
  localparam int TIMEOUT_NS = 5_000_000;

  typedef struct packed {
    logic [0:0]       idx;
    logic [CNT_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [0:0]        cfg_index = '0;
  logic [CNT_W-1:0]  cfg_data = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [79:0]       m_axis_tdata;
  logic [0:0]        m_axis_tuser;

  // Pending stimulus and outstanding neighbour lists
  logic [ID_W-1:0]   query_q[$];
  reg_write_t        reg_write_q[$];
  m3nl_pkg::out_t    neighbour_q[$];

  // Local copy of the two registers, updated as writes are accepted
  logic [CNT_W-1:0]  mesh_nodes;
  logic [EDGE_W-1:0] mesh_side;

  int queued_total = 0;   // queries handed to the driver
  int results_seen = 0;   // words taken from m_axis
  int writes_sent  = 0;
  int writes_done  = 0;
  int errors       = 0;
  int in_hold      = 0;
  int in_calm      = 0;
  int out_hold     = 0;
  int out_calm     = 0;
  reg_write_t next_write;

  mesh3d_neighbor_list #(
    .MAX_NODES(NODE_LIMIT)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Face neighbours of one node: split into x/y/z, try x-1, y-1, z-1, x+1, y+1, z+1.
  // Only the moved coordinate is range-checked against the edge; the linear
  // index must also fall below the (clamped) node count.
  function automatic m3nl_pkg::out_t neighbours_of(input logic [ID_W-1:0] id,
                                                   input logic [CNT_W-1:0] nodes,
                                                   input logic [EDGE_W-1:0] side);
    m3nl_pkg::out_t r;
    int   w, lim, x, y, z, cx, cy, cz, step, moved, idx;
    r   = '0;
    w   = (side == 0) ? 1 : int'(side);               // zero edge acts as one
    lim = (nodes > NODE_LIMIT) ? NODE_LIMIT : int'(nodes);
    if (int'(id) >= lim) begin
      r.bad = 1'b1;                                    // also covers zero count
      return r;
    end
    x = id / (w * w);
    y = (id % (w * w)) / w;
    z = id % w;
    for (int d = 0; d < NUM_DIRS; d++) begin
      step = (d < 3) ? -1 : 1;
      cx = x;
      cy = y;
      cz = z;
      case (d % 3)
        0: begin
          cx = x + step;
          moved = cx;
        end
        1: begin
          cy = y + step;
          moved = cy;
        end
        default: begin
          cz = z + step;
          moved = cz;
        end
      endcase
      idx = cx * w * w + cy * w + cz;
      if (moved >= 0 && moved < w && idx >= 0 && idx < lim) begin
        r.nb[r.count] = idx[ID_W-1:0];
        r.count = r.count + 3'd1;
      end
    end
    return r;
  endfunction

  // Idle length: mostly none or short, now and then long, plus runs with no idling
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report(input string field, input int want, input int got);
    $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    errors++;
  endtask

  // Driver: register writes and query words.
  // Handshakes are judged on the values present at the edge; the model's
  // registers follow each accepted write, and every accepted query appends
  // its predicted neighbour list.
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid     <= 1'b0;
      s_axis_tvalid <= 1'b0;
      mesh_nodes    = 13'd1;
      mesh_side     = 5'd1;
      in_hold       = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == m3nl_pkg::REG_NODE_COUNT)
          mesh_nodes = cfg_data;
        else if (cfg_index == m3nl_pkg::REG_EDGE_WIDTH)
          mesh_side = cfg_data[EDGE_W-1:0];
        writes_done++;
      end
      if (reg_write_q.size() != 0 && (!cfg_valid || cfg_ready)) begin
        next_write = reg_write_q.pop_front();
        cfg_valid <= 1'b1;
        cfg_index <= next_write.idx;
        cfg_data  <= next_write.data;
      end else if (cfg_valid && cfg_ready) begin
        cfg_valid <= 1'b0;
      end

      if (s_axis_tvalid && s_axis_tready)
        neighbour_q.insert(neighbour_q.size(),
                           neighbours_of(s_axis_tdata[ID_W-1:0], mesh_nodes, mesh_side));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (in_hold > 0) begin
          in_hold--;
          s_axis_tvalid <= 1'b0;
        end else if (query_q.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, query_q.pop_front()};
          in_hold = pick_gap(in_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: unpack each accepted word, compare against the oldest prediction,
  // and apply random back-pressure on m_axis.
  always @(posedge clk) begin
    m3nl_pkg::out_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
      out_hold = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        got.bad   = m_axis_tuser[0];
        got.count = m_axis_tdata[2:0];
        for (int i = 0; i < NUM_DIRS; i++)
          got.nb[i] = m_axis_tdata[3 + ID_W * i +: ID_W];
        if (neighbour_q.size() == 0) begin
          $display("%0t ns: unexpected word, count %0d bad_node %0b", $time,
                   got.count, got.bad);
          errors++;
        end else begin
          want = neighbour_q.pop_front();
          if (got.count != want.count) report("neighbor_count", want.count, got.count);
          if (got.bad != want.bad) report("bad_node", want.bad, got.bad);
          for (int i = 0; i < NUM_DIRS; i++)
            if (got.nb[i] != want.nb[i])
              report($sformatf("neighbor_%0d", i), want.nb[i], got.nb[i]);
        end
      end
      if (out_hold > 0) begin
        out_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        out_hold = pick_gap(out_calm);
      end
    end
  end

  task automatic send(input int id);
    query_q.insert(query_q.size(), id[ID_W-1:0]);
    queued_total++;
  endtask

  // Wait for every queued query to come back, then let the pipe settle
  task automatic drain();
    while (results_seen < queued_total) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Registers change only with the pipeline empty
  task automatic set_mesh(input int nodes, input int side);
    drain();
    reg_write_q.insert(reg_write_q.size(),
                       {m3nl_pkg::REG_NODE_COUNT, nodes[CNT_W-1:0]});
    reg_write_q.insert(reg_write_q.size(),
                       {m3nl_pkg::REG_EDGE_WIDTH, side[CNT_W-1:0]});
    writes_sent += 2;
    while (writes_done < writes_sent) @(posedge clk);
  endtask

  initial begin
    int nodes, side, cube, lim, id;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset values: one node, edge one
    send(0); send(1); send(4095);
    // Full 3x3x3 cube: corner, centre with all six, far corner, first bad id
    set_mesh(27, 3);
    send(0); send(13); send(26); send(27);
    // Zero count: everything bad
    set_mesh(0, 5);
    send(0);
    // Zero edge behaves as edge one
    set_mesh(5, 0);
    send(0); send(4); send(5);
    // Count above MAX_NODES is clamped
    set_mesh(8191, 16);
    send(0); send(2048); send(4095); send(1365);
    // Edge too small for the count: x runs past the edge
    set_mesh(100, 2);
    send(7); send(50); send(99);
    // Widest edge register value
    set_mesh(4096, 31);
    send(4095); send(961);
    // Partly filled cube: neighbours cut off by the count
    set_mesh(20, 3);
    send(10); send(19);

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          nodes = 4096;
          side  = 16;
        end
        1: begin
          nodes = 8191;
          side  = 31;
        end
        2: begin
          nodes = 0;
          side  = 0;
        end
        3: begin
          nodes = 1;
          side  = 1;
        end
        default: begin
          side = $urandom_range(1, 16);
          cube = side * side * side;
          case ($urandom_range(0, 5))
            0:       nodes = cube;
            1, 2, 3: nodes = $urandom_range((side - 1) * (side - 1) * (side - 1) + 1, cube);
            4:       nodes = $urandom_range(0, 8191);
            default: begin
              side  = $urandom_range(0, 31);
              nodes = $urandom_range(0, 4096);
            end
          endcase
        end
      endcase
      set_mesh(nodes, side);
      lim = (nodes > NODE_LIMIT) ? NODE_LIMIT : nodes;
      // Mostly valid node numbers; the rest anywhere in the field
      for (int k = 0; k < PHASE_LEN; k++) begin
        if (lim > 0 && $urandom_range(0, 9) < 8)
          id = $urandom_range(0, lim - 1);
        else
          id = $urandom_range(0, 4095);
        send(id);
      end
    end

    drain();
    if (neighbour_q.size() != 0) begin
      $display("%0t ns: %0d neighbour lists never returned", $time, neighbour_q.size());
      errors++;
    end
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/m3nl_pkg.sv
rtl/mesh3d_neighbor_list.sv
sim/mesh3d_neighbor_list_tb.sv
